// ----- src/bdq_pkg.sv -----
// Shared types, constants and word-width helpers for the bounded deque.
// Used by bdq_cell and bounded_deque_with_search_top. No dependencies.
`default_nettype none

package bdq_pkg;

  // Store geometry
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // Port field widths (fixed by the interface)
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_SEARCH     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  // Request and response payloads
  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
  } bdq_req_t;

  typedef struct packed {
    status_e                   status;
    logic signed [VALUE_W-1:0] word;
    logic [POS_W-1:0]          position;
    logic [COUNT_W-1:0]        count;
  } bdq_rsp_t;

  // Shift/load controls broadcast to every cell
  typedef struct packed {
    logic  push_front;
    logic  pop_front;
    logic  push_back;
    word_t value;
  } cell_ctl_t;

  // Sign-extend (or truncate) a port value into a stored word
  function automatic word_t widen_value(input logic signed [VALUE_W-1:0] v);
    logic signed [63:0] t;
    t = 64'(v);
    return t[DATA_WIDTH-1:0];
  endfunction

  // Sign-extend a stored word, keep the low port bits
  function automatic logic signed [VALUE_W-1:0] narrow_word(input word_t w);
    logic signed [63:0] t;
    t = 64'($signed(w));
    return t[VALUE_W-1:0];
  endfunction

  // Front-relative index reported modulo the position field
  function automatic logic [POS_W-1:0] to_pos(input idx_t i);
    logic [31:0] t;
    t = 32'(i);
    return t[POS_W-1:0];
  endfunction

  // Entry count reported modulo the count field
  function automatic logic [COUNT_W-1:0] to_count(input cnt_t c);
    logic [31:0] t;
    t = 32'(c);
    return t[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/bdq_cell.sv -----
// One deque slot: holds the word at a fixed front-relative position.
// Depends on bdq_pkg for the word and control types.
`default_nettype none

module bdq_cell
  import bdq_pkg::*;
(
  input  wire       clk_i,
  input  cell_ctl_t ctl_i,
  input  wire       back_sel_i,  // this slot is the first free one at the back
  input  word_t     lower_i,     // neighbor nearer the front (value at slot 0)
  input  word_t     upper_i,     // neighbor nearer the back
  input  word_t     key_i,
  output word_t     data_o,
  output logic      match_o
);

  word_t data_q, data_d;

  // Push front shifts backward, pop front forward; push back loads if selected
  always_comb begin
    data_d = data_q;
    if (ctl_i.push_front) begin
      data_d = lower_i;
    end else if (ctl_i.pop_front) begin
      data_d = upper_i;
    end else if (ctl_i.push_back && back_sel_i) begin
      data_d = ctl_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Local comparator for the broadcast search
  assign match_o = (data_q == key_i);
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- src/bounded_deque_with_search_top.sv -----
// Bounded double-ended queue with a broadcast search over a row of cells.
// Depends on bdq_pkg and bdq_cell.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-------------------------------
//   request | in_valid_i / in_ready_o   | in_data_i  (mode, value)
//   result  | out_valid_o / out_ready_i | out_data_o (status, word,
//           |                           |             position, count)
//
// One request per cycle while the result register is empty or being drained;
// its result appears in the cycle after acceptance. Entries sit in front order
// in the cells, so each change to them is one shift or load of the row; search
// compares all cells at once and picks the match nearest the front. Reset empties
// the deque; cell contents need no clearing.
`default_nettype none

module bounded_deque_with_search_top
  import bdq_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_ready_o,
  input  bdq_req_t in_data_i,
  output logic     out_valid_o,
  input  wire      out_ready_i,
  output bdq_rsp_t out_data_o
);

  cnt_t      count_q, count_d;
  logic      out_valid_q;
  bdq_rsp_t  rsp_q, rsp_d;
  cell_ctl_t ctl;
  word_t     key;
  word_t     cell_data [DEPTH];
  logic [DEPTH-1:0] match, hit, back_sel, tail_sel;
  logic      accept, full, empty, any_hit;
  idx_t      hit_idx;
  word_t     tail_word;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign key        = widen_value(in_data_i.value);

  // Row controls
  always_comb begin
    ctl.push_front = accept && (in_data_i.mode == MODE_PUSH_FRONT) && !full;
    ctl.push_back  = accept && (in_data_i.mode == MODE_PUSH_BACK) && !full;
    ctl.pop_front  = accept && (in_data_i.mode == MODE_POP_FRONT) && !empty;
    ctl.value      = key;
  end

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t lower, upper;
    if (i == 0) begin : g_first
      assign lower = key;
    end else begin : g_mid
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_inner
      assign upper = cell_data[i+1];
    end

    assign back_sel[i] = (count_q == CNT_W'(i));
    assign tail_sel[i] = (count_q == CNT_W'(i + 1));
    assign hit[i]      = match[i] && (CNT_W'(i) < count_q);

    bdq_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .back_sel_i (back_sel[i]),
      .lower_i    (lower),
      .upper_i    (upper),
      .key_i      (key),
      .data_o     (cell_data[i]),
      .match_o    (match[i])
    );
  end

  // Tail word for pop back: AND-OR select of the last held cell
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_word = tail_word | (cell_data[i] & {DATA_WIDTH{tail_sel[i]}});
    end
  end

  // First match from the front
  always_comb begin
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end
  assign any_hit = |hit;

  // Result and count update
  always_comb begin
    count_d = count_q;
    rsp_d   = rsp_q;
    if (accept) begin
      rsp_d.status   = ST_OK;
      rsp_d.word     = '0;
      rsp_d.position = '0;
      unique case (in_data_i.mode) inside
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (full) begin
            rsp_d.status = ST_FULL;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        MODE_POP_FRONT: begin
          if (empty) begin
            rsp_d.status = ST_NOTFOUND;
          end else begin
            rsp_d.word = narrow_word(cell_data[0]);
            count_d    = count_q - 1'b1;
          end
        end
        MODE_POP_BACK: begin
          if (empty) begin
            rsp_d.status = ST_NOTFOUND;
          end else begin
            rsp_d.word = narrow_word(tail_word);
            count_d    = count_q - 1'b1;
          end
        end
        MODE_SEARCH: begin
          if (any_hit) begin
            rsp_d.word     = narrow_word(key);
            rsp_d.position = to_pos(hit_idx);
          end else begin
            rsp_d.status = ST_NOTFOUND;
          end
        end
        default: begin
        end
      endcase
      rsp_d.count = to_count(count_d);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.push_front || ctl.push_back) |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not grow the deque");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("request taken while result stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o && out_data_o.count == to_count(count_q))
    else $error("result missing or count mismatch");

endmodule

`default_nettype wire
